### hdl/asfd_pkg.sv
// shared types, constants and field tables for the air sensor frame decoder
// depends on nothing; imported by the controller, datapath and top level
`default_nettype none

package asfd_pkg;

  localparam int FRAME_LENGTH = 40;
  localparam int SUM_BYTES    = 36;
  localparam int NUM_FIELDS   = 13;
  localparam int ADDR_W       = $clog2(FRAME_LENGTH);
  localparam int FIELD_W      = $clog2(NUM_FIELDS);

  localparam logic [7:0]  HEADER_RESET = 8'd170;

  // checksums that the sensor sends when nothing is attached
  localparam logic [15:0] NC_SUM_A = 16'd243;
  localparam logic [15:0] NC_SUM_B = 16'd244;
  localparam logic [15:0] NC_SUM_C = 16'd680;

  localparam logic [1:0] STAT_READING  = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_NOCONN   = 2'd2;

  // frame offset of the high byte of each reading
  localparam logic [ADDR_W-1:0] FIELD_OFFSET [NUM_FIELDS] = '{
    ADDR_W'(1),  ADDR_W'(3),  ADDR_W'(5),  ADDR_W'(7),  ADDR_W'(9),
    ADDR_W'(11), ADDR_W'(13), ADDR_W'(19), ADDR_W'(21), ADDR_W'(23),
    ADDR_W'(25), ADDR_W'(27), ADDR_W'(29)
  };

  // strict limits in raw units; temperature and humidity in hundredths
  localparam logic [15:0] FIELD_LOW [NUM_FIELDS] = '{
    16'd0, 16'd0, 16'd0, 16'd0, 16'd350, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };
  localparam logic [15:0] FIELD_HIGH [NUM_FIELDS] = '{
    16'd999, 16'd999, 16'd3000, 16'd2000, 16'd5000, 16'd8500, 16'd9900,
    16'd5000, 16'd2000, 16'd1000, 16'd100, 16'd50, 16'd25
  };
  // temperature has no effective lower limit
  localparam logic FIELD_HAS_LOW [NUM_FIELDS] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_CHK_RD,
    ST_CHK,
    ST_FLD_RD,
    ST_FLD_LOAD,
    ST_SEND
  } asfd_state_t;

  typedef struct packed {
    logic start_frame;
    logic store_byte;
    logic rd_chk;
    logic load_status;
    logic rd_field;
    logic load_field;
    logic next_field;
  } asfd_cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic count_end;
    logic chk_bad;
    logic out_last;
  } asfd_sts_t;

endpackage

`default_nettype wire

### hdl/asfd_datapath.sv
// frame store, checksum accumulator, range check and result registers
// depends on asfd_pkg; driven by asfd_ctrl through asfd_cmd_t
`default_nettype none

module asfd_datapath import asfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire asfd_cmd_t         cmd,
  output asfd_sts_t              sts,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  output logic      [1:0]        out_status,
  output logic      [3:0]        out_field_id,
  output logic      [15:0]       out_raw_value,
  output logic                   out_in_range,
  output logic                   out_last
);

  logic [7:0]         header_byte_r;
  logic [ADDR_W-1:0]  byte_count_r, byte_count_nxt;
  logic [15:0]        running_sum_r, running_sum_nxt;
  logic [FIELD_W-1:0] field_idx_r, field_idx_nxt;
  logic [7:0]         frame_store_r [FRAME_LENGTH];
  logic [7:0]         rd_hi_r, rd_lo_r;
  logic [ADDR_W-1:0]  wr_addr, rd_addr_hi, rd_addr_lo;
  logic               wr_en, rd_en;
  logic [15:0]        word;
  logic               sum_ok, noconn, field_ok;

  logic [1:0]         out_status_r;
  logic [3:0]         out_field_id_r;
  logic [15:0]        out_raw_value_r;
  logic               out_in_range_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= HEADER_RESET;
    end else if (cfg_wr_en) begin
      header_byte_r <= cfg_wr_data;
    end
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    if (cmd.start_frame) begin
      byte_count_nxt  = ADDR_W'(1);
      running_sum_nxt = {8'd0, in_rx_byte};
    end else if (cmd.store_byte) begin
      byte_count_nxt = byte_count_r + ADDR_W'(1);
      if (byte_count_r < ADDR_W'(SUM_BYTES)) begin
        running_sum_nxt = running_sum_r + {8'd0, in_rx_byte};
      end
    end
  end

  always_comb begin
    field_idx_nxt = field_idx_r;
    if (cmd.rd_chk) begin
      field_idx_nxt = '0;
    end else if (cmd.next_field) begin
      field_idx_nxt = field_idx_r + FIELD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= '0;
      field_idx_r   <= '0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      field_idx_r   <= field_idx_nxt;
    end
  end

  // byte store: one write port, two registered read ports
  assign wr_en      = cmd.start_frame | cmd.store_byte;
  assign wr_addr    = cmd.start_frame ? '0 : byte_count_r;
  assign rd_en      = cmd.rd_chk | cmd.rd_field;
  assign rd_addr_hi = cmd.rd_chk ? ADDR_W'(SUM_BYTES) : FIELD_OFFSET[field_idx_r];
  assign rd_addr_lo = rd_addr_hi + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store_r[wr_addr] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hi_r <= frame_store_r[rd_addr_hi];
      rd_lo_r <= frame_store_r[rd_addr_lo];
    end
  end

  assign word     = {rd_hi_r, rd_lo_r};
  assign sum_ok   = (word == running_sum_r);
  assign noconn   = word inside {NC_SUM_A, NC_SUM_B, NC_SUM_C};
  assign field_ok = (word < FIELD_HIGH[field_idx_r]) &&
                    (!FIELD_HAS_LOW[field_idx_r] || (word > FIELD_LOW[field_idx_r]));

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_status_r    <= sum_ok ? STAT_NOCONN : STAT_MISMATCH;
      out_field_id_r  <= '0;
      out_raw_value_r <= word;
      out_in_range_r  <= 1'b0;
      out_last_r      <= 1'b1;
    end else if (cmd.load_field) begin
      out_status_r    <= STAT_READING;
      out_field_id_r  <= 4'(field_idx_r);
      out_raw_value_r <= word;
      out_in_range_r  <= field_ok;
      out_last_r      <= (field_idx_r == FIELD_W'(NUM_FIELDS - 1));
    end
  end

  assign sts.hdr_match = (in_rx_byte == header_byte_r);
  assign sts.count_end = (byte_count_r == ADDR_W'(FRAME_LENGTH - 1));
  assign sts.chk_bad   = !sum_ok || noconn;
  assign sts.out_last  = out_last_r;

  assign out_status    = out_status_r;
  assign out_field_id  = out_field_id_r;
  assign out_raw_value = out_raw_value_r;
  assign out_in_range  = out_in_range_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

### hdl/asfd_ctrl.sv
// controller state machine: hunt, collect, checksum check, reading release
// depends on asfd_pkg; commands asfd_datapath through asfd_cmd_t
`default_nettype none

module asfd_ctrl import asfd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire asfd_sts_t sts,
  output asfd_cmd_t      cmd
);

  asfd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (in_valid && sts.hdr_match) state_nxt = ST_COLLECT;
      end
      ST_COLLECT: begin
        if (in_valid && sts.count_end) state_nxt = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = sts.chk_bad ? ST_SEND : ST_FLD_RD;
      end
      ST_FLD_RD: begin
        state_nxt = ST_FLD_LOAD;
      end
      ST_FLD_LOAD: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) state_nxt = sts.out_last ? ST_HUNT : ST_FLD_RD;
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_HUNT: begin
        in_ready        = 1'b1;
        cmd.start_frame = in_valid && sts.hdr_match;
      end
      ST_COLLECT: begin
        in_ready       = 1'b1;
        cmd.store_byte = in_valid;
      end
      ST_CHK_RD: begin
        cmd.rd_chk = 1'b1;
      end
      ST_CHK: begin
        cmd.load_status = sts.chk_bad;
      end
      ST_FLD_RD: begin
        cmd.rd_field = 1'b1;
      end
      ST_FLD_LOAD: begin
        cmd.load_field = 1'b1;
      end
      ST_SEND: begin
        out_valid      = 1'b1;
        cmd.next_field = out_ready && !sts.out_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/air_sensor_frame_decoder_core.sv
// top level of the air sensor frame decoder: controller plus datapath
// depends on asfd_pkg, asfd_ctrl and asfd_datapath
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_rx_byte
// out      output     out_valid/out_ready  out_status, out_field_id, out_raw_value,
//                                          out_in_range, out_last
// cfg      input      cfg_wr_en            cfg_wr_data (header byte)
//
// one byte is taken per cycle while hunting or collecting a frame
// after the final byte of a frame the input stalls: the checksum is read and
// compared, then each of the 13 readings of a good frame takes a store read, a
// load and a transfer that waits for out_ready; a rejected frame gives one result
// the dual-read byte store and the single result register set these steps
// synchronous active-low reset returns to hunting with header byte 170
`default_nettype none

module air_sensor_frame_decoder_core import asfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  out_status,
  output logic      [3:0]  out_field_id,
  output logic      [15:0] out_raw_value,
  output logic             out_in_range,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  asfd_cmd_t cmd;
  asfd_sts_t sts;

  // sequencing: which step runs, when bytes are taken and results shown
  asfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // byte store, checksum sum and the result registers
  asfd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_rx_byte    (in_rx_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_status    (out_status),
    .out_field_id  (out_field_id),
    .out_raw_value (out_raw_value),
    .out_in_range  (out_in_range),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  // input and result sides never run at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // the final transfer of a frame returns to hunting
  a_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("no return to hunting after final transfer");

  // a rejected frame is a single result
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_READING) |-> out_last && !out_in_range)
    else $error("rejected frame result not final");

  // readings other than the last one are followed by another reading
  a_next_reading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("frame readings cut short");
`endif

endmodule

`default_nettype wire

### verif/asfd_reading_checker.sv
`timescale 1ns / 1ps
// result checker for the air sensor frame decoder: decodes the accepted bytes itself
// and compares every result transfer; depends on asfd_pkg for status codes, sensor-absent checksums and header reset

module asfd_reading_checker import asfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_field_id,
  input  logic [15:0] out_raw_value,
  input  logic        out_in_range,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          error_count,
  output int          readings_owed,
  output logic        awaiting_header,
  output int          results_checked,
  output int          frames_rejected
);

  localparam int FRAME_BYTES = 40;
  localparam int SUM_SPAN    = 36;
  localparam int READINGS    = 13;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  field_id;
    logic [15:0] raw_value;
    logic        in_range;
    logic        last;
  } reading_t;

  reading_t    owed_q [$];
  logic [7:0]  header_sel;
  logic        hunting;
  logic [5:0]  byte_idx;
  logic [15:0] byte_total;
  logic [7:0]  frame_mem [FRAME_BYTES];

  // strict limits per reading, temperature has no lower one
  function automatic logic reading_ok(input int k, input logic [15:0] v);
    case (k)
      0, 1:    return v > 0 && v < 999;
      2:       return v > 0 && v < 3000;
      3:       return v > 0 && v < 2000;
      4:       return v > 350 && v < 5000;
      5:       return v < 8500;
      6:       return v > 0 && v < 9900;
      7:       return v > 0 && v < 5000;
      8:       return v > 0 && v < 2000;
      9:       return v > 0 && v < 1000;
      10:      return v > 0 && v < 100;
      11:      return v > 0 && v < 50;
      default: return v > 0 && v < 25;
    endcase
  endfunction

  task automatic owe(input logic [1:0] st, input logic [3:0] id, input logic [15:0] raw,
                     input logic ok, input logic fin);
    owed_q.push_back({st, id, raw, ok, fin});
  endtask

  task automatic release_frame_results();
    logic [15:0] rx_total;
    logic [15:0] v;
    int          off;
    rx_total = {frame_mem[SUM_SPAN], frame_mem[SUM_SPAN+1]};
    if (rx_total != byte_total) begin
      owe(STAT_MISMATCH, 4'd0, rx_total, 1'b0, 1'b1);
      frames_rejected++;
    end else if (rx_total == NC_SUM_A || rx_total == NC_SUM_B || rx_total == NC_SUM_C) begin
      owe(STAT_NOCONN, 4'd0, rx_total, 1'b0, 1'b1);
      frames_rejected++;
    end else begin
      for (int k = 0; k < READINGS; k++) begin
        off = (k < 7) ? 2 * k + 1 : 2 * k + 5;
        v = {frame_mem[off], frame_mem[off+1]};
        owe(STAT_READING, 4'(k), v, reading_ok(k, v), k == READINGS - 1);
      end
    end
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b);
    if (hunting && b != header_sel) return;
    if (hunting) begin
      hunting    = 1'b0;
      byte_idx   = '0;
      byte_total = '0;
    end
    frame_mem[byte_idx] = b;
    if (byte_idx < SUM_SPAN) byte_total = byte_total + 16'(b);
    if (byte_idx == FRAME_BYTES - 1) begin
      hunting  = 1'b1;
      byte_idx = '0;
      release_frame_results();
    end else begin
      byte_idx = byte_idx + 1'b1;
    end
  endtask

  task automatic check_field(input string what, input logic [3:0] id,
                             input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: reading %0d %s expected %0d got %0d", $time, id, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      header_sel      = HEADER_RESET;
      hunting         = 1'b1;
      byte_idx        = '0;
      byte_total      = '0;
      owed_q.delete();
      error_count     = 0;
      results_checked = 0;
      frames_rejected = 0;
    end else begin
      if (cfg_wr_en) header_sel = cfg_wr_data;
      if (in_valid && in_ready) absorb_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got = {out_status, out_field_id, out_raw_value, out_in_range, out_last};
        if (owed_q.size() == 0) begin
          error_count++;
          $display("%0t ns: result expected none got status %0d id %0d value %0d", $time,
                   got.status, got.field_id, got.raw_value);
        end else begin
          want = owed_q.pop_front();
          check_field("status", want.field_id, 16'(want.status), 16'(got.status));
          check_field("field_id", want.field_id, 16'(want.field_id), 16'(got.field_id));
          check_field("raw_value", want.field_id, want.raw_value, got.raw_value);
          check_field("in_range", want.field_id, 16'(want.in_range), 16'(got.in_range));
          check_field("last", want.field_id, 16'(want.last), 16'(got.last));
          results_checked++;
        end
      end
    end
    readings_owed   = owed_q.size();
    awaiting_header = hunting;
  end

endmodule

### verif/air_sensor_frame_decoder_core_test.sv
`timescale 1ns / 1ps
// stimulus and verdict for air_sensor_frame_decoder_core: sends frames and noise bytes
// under random gaps and stalls; depends on asfd_pkg, the core and asfd_reading_checker

module air_sensor_frame_decoder_core_test;
  import asfd_pkg::*;

  // what a built frame is meant to provoke
  typedef enum int {
    KIND_GOOD,
    KIND_CORRUPT,
    KIND_UNPLUGGED
  } frame_kind_t;

  // how a reading value is drawn relative to its limits
  typedef enum int {
    VAL_INNER_LOW,
    VAL_INNER_HIGH,
    VAL_AT_LOW,
    VAL_AT_HIGH,
    VAL_ALL_ONES,
    VAL_EDGE,
    VAL_INSIDE,
    VAL_ANY,
    VAL_MIXED
  } value_mode_t;

  localparam int PHASE_BYTES  = 40;    // minimum frame bytes per random phase, four phases
  localparam int DRAIN_CYCLES = 48;    // idle cycles waited after every result has drained
  localparam int STALL_LIMIT  = 4000;  // cycles without any transfer before giving up

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_ready   = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_field_id;
  logic [15:0] out_raw_value;
  logic        out_in_range;
  logic        out_last;

  int   error_count;
  int   readings_owed;
  logic awaiting_header;
  int   results_checked;
  int   frames_rejected;

  // stimulus bookkeeping
  logic [7:0]  header_now       = HEADER_RESET;
  logic [7:0]  frame_img [FRAME_LENGTH];
  logic [15:0] frame_total;
  logic        calm_stretch     = 1'b0;
  int          frame_bytes_sent = 0;
  int          noise_bytes_sent = 0;
  int          quiet_cycles     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  air_sensor_frame_decoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_field_id  (out_field_id),
    .out_raw_value (out_raw_value),
    .out_in_range  (out_in_range),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // independent decode of the byte stream, compares every result transfer
  asfd_reading_checker reading_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_field_id    (out_field_id),
    .out_raw_value   (out_raw_value),
    .out_in_range    (out_in_range),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .error_count     (error_count),
    .readings_owed   (readings_owed),
    .awaiting_header (awaiting_header),
    .results_checked (results_checked),
    .frames_rejected (frames_rejected)
  );

  // per-transfer wait, zero throughout a calm stretch
  function automatic int draw_gap();
    return calm_stretch ? 0 : $urandom_range(0, 15);
  endfunction

  // reading value for field k, drawn around its strict limits
  function automatic logic [15:0] pick_reading(input int k, input value_mode_t mode);
    logic [15:0] lo;
    logic [15:0] hi;
    value_mode_t m;
    lo = FIELD_LOW[k];
    hi = FIELD_HIGH[k];
    m  = mode;
    if (m == VAL_MIXED) begin
      case ($urandom_range(0, 3))
        0:       m = VAL_EDGE;
        1:       m = VAL_INSIDE;
        default: m = VAL_ANY;
      endcase
    end
    case (m)
      VAL_INNER_LOW:  return lo + 16'd1;
      VAL_INNER_HIGH: return hi - 16'd1;
      VAL_AT_LOW:     return lo;
      VAL_AT_HIGH:    return hi;
      VAL_ALL_ONES:   return 16'hffff;
      VAL_INSIDE:     return 16'($urandom_range(lo + 1, hi - 1));
      VAL_EDGE: begin
        case ($urandom_range(0, 6))
          0:       return 16'h0000;
          1:       return lo;
          2:       return lo + 16'd1;
          3:       return hi - 16'd1;
          4:       return hi;
          5:       return hi + 16'd1;
          default: return 16'hffff;
        endcase
      end
      default:        return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // fills frame_img with a full frame under the current header
  task automatic build_frame(input frame_kind_t kind, input value_mode_t even_mode,
                             input value_mode_t odd_mode, input logic [15:0] nc_sum);
    int          total;
    int          left;
    int          take;
    logic [15:0] v;
    logic [15:0] chk;
    logic [15:0] goal;
    foreach (frame_img[i]) frame_img[i] = 8'($urandom_range(0, 255));
    frame_img[0] = header_now;
    if (kind == KIND_UNPLUGGED) begin
      // spread the remainder over the summed bytes so the checksum lands on goal
      goal = (nc_sum < header_now) ? NC_SUM_C : nc_sum;
      left = int'(goal) - int'(header_now);
      for (int i = 1; i < SUM_BYTES; i++) begin
        take = $urandom_range(0, left > 255 ? 255 : left);
        frame_img[i] = 8'(take);
        left -= take;
      end
      for (int i = 1; i < SUM_BYTES && left > 0; i++) begin
        take = 255 - int'(frame_img[i]);
        if (take > left) take = left;
        frame_img[i] = frame_img[i] + 8'(take);
        left -= take;
      end
    end else begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
        v = pick_reading(k, (k % 2 == 0) ? even_mode : odd_mode);
        frame_img[FIELD_OFFSET[k]]     = v[15:8];
        frame_img[FIELD_OFFSET[k] + 1] = v[7:0];
      end
    end
    total = 0;
    for (int i = 0; i < SUM_BYTES; i++) total += int'(frame_img[i]);
    chk = 16'(total);
    // corrupt frames get a checksum that can no longer match
    if (kind == KIND_CORRUPT) chk = chk ^ 16'($urandom_range(1, 65535));
    frame_img[SUM_BYTES]     = chk[15:8];
    frame_img[SUM_BYTES + 1] = chk[7:0];
    frame_total = 16'(total);
  endtask

  // one input transfer; returns at the falling edge after acceptance with valid still high
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // the first len bytes of frame_img; a short len leaves a broken frame behind
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(frame_img[i]);
    frame_bytes_sent += len;
  endtask

  // bytes that never match the header, dropped while hunting
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == header_now);
      send_byte(b);
    end
    noise_bytes_sent += n;
  endtask

  // finish any open frame, go idle and let every result drain out
  task automatic settle();
    while (!awaiting_header) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    while (readings_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    header_now   = value;
  endtask

  task automatic directed_part();
    // byte extremes that are not the header are dropped while hunting
    send_byte(8'h00);
    send_byte(8'hff);
    noise_bytes_sent += 2;
    // readings just inside or on a limit, low side even, high side odd, then all ones
    build_frame(KIND_GOOD, VAL_INNER_LOW, VAL_AT_HIGH, NC_SUM_A);
    send_frame(FRAME_LENGTH);
    build_frame(KIND_GOOD, VAL_AT_LOW, VAL_INNER_HIGH, NC_SUM_A);
    send_frame(FRAME_LENGTH);
    build_frame(KIND_GOOD, VAL_ALL_ONES, VAL_ALL_ONES, NC_SUM_A);
    send_frame(FRAME_LENGTH);
    // checksum mismatch
    build_frame(KIND_CORRUPT, VAL_ANY, VAL_ANY, NC_SUM_A);
    send_frame(FRAME_LENGTH);
    // each sensor-absent checksum
    build_frame(KIND_UNPLUGGED, VAL_ANY, VAL_ANY, NC_SUM_A);
    send_frame(FRAME_LENGTH);
    build_frame(KIND_UNPLUGGED, VAL_ANY, VAL_ANY, NC_SUM_B);
    send_frame(FRAME_LENGTH);
    build_frame(KIND_UNPLUGGED, VAL_ANY, VAL_ANY, NC_SUM_C);
    send_frame(FRAME_LENGTH);
    // sensor-absent value received but the sum disagrees: mismatch wins
    build_frame(KIND_GOOD, VAL_ANY, VAL_ANY, NC_SUM_A);
    {frame_img[SUM_BYTES], frame_img[SUM_BYTES + 1]} = (frame_total == NC_SUM_C) ?
                                                       NC_SUM_A : NC_SUM_C;
    send_frame(FRAME_LENGTH);
  endtask

  // mostly well-formed frames with random content, plus noise and broken frames
  task automatic random_part(input int quota);
    int          first;
    int          r;
    logic [15:0] nc_pick;
    first = frame_bytes_sent;
    while (frame_bytes_sent - first < quota) begin
      calm_stretch = ($urandom_range(0, 3) == 0);
      send_noise($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       nc_pick = NC_SUM_A;
        1:       nc_pick = NC_SUM_B;
        default: nc_pick = NC_SUM_C;
      endcase
      if (r < 60) begin
        build_frame(KIND_GOOD, VAL_MIXED, VAL_MIXED, nc_pick);
        send_frame(FRAME_LENGTH);
      end else if (r < 75) begin
        build_frame(KIND_CORRUPT, VAL_MIXED, VAL_MIXED, nc_pick);
        send_frame(FRAME_LENGTH);
      end else if (r < 85) begin
        build_frame(KIND_UNPLUGGED, VAL_ANY, VAL_ANY, nc_pick);
        send_frame(FRAME_LENGTH);
      end else begin
        // cut short, the bytes that follow land inside the open frame
        build_frame(KIND_GOOD, VAL_MIXED, VAL_MIXED, nc_pick);
        send_frame($urandom_range(1, FRAME_LENGTH - 1));
      end
    end
    calm_stretch = 1'b0;
  endtask

  // result side: a fresh stall before every result transfer
  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // give up after a long stretch with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results still owed", $time,
               quiet_cycles, readings_owed);
      $display("air_sensor_frame_decoder_core_test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] mid_header;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // header at its reset value
    directed_part();
    settle();

    // header extremes, a random one, then back to the usual value
    mid_header = 8'($urandom_range(1, 254));
    write_header(8'h00);
    random_part(PHASE_BYTES);
    settle();
    write_header(8'hff);
    random_part(PHASE_BYTES);
    settle();
    write_header(mid_header);
    random_part(PHASE_BYTES);
    settle();
    write_header(HEADER_RESET);
    random_part(PHASE_BYTES);
    settle();

    $display("covered %0d frame bytes and %0d dropped bytes under headers 170, 0, 255, %0d",
             frame_bytes_sent, noise_bytes_sent, mid_header);
    $display("compared %0d results, %0d of them rejected frames", results_checked,
             frames_rejected);
    if (error_count == 0 && readings_owed == 0) begin
      $display("air_sensor_frame_decoder_core_test passed");
    end else begin
      $display("air_sensor_frame_decoder_core_test failed");
    end
    $finish;
  end

endmodule
